// ----- hw/rtl/tzc_pkg.sv -----
// tzc_pkg: shared types and codes for the time zone transition converter.
// No dependencies; used by tzc_ctrl, tzc_dpath and timezone_transition_convert.
`default_nettype none

package tzc_pkg;

  // Operation carried by an input item
  typedef enum logic [1:0] {
    OP_TO_LOCAL   = 2'd0,
    OP_TO_UTC     = 2'd1,
    OP_LOAD_TRANS = 2'd2,
    OP_LOAD_TYPE  = 2'd3
  } opcode_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_OP    = 3'd1,
    ST_NOT_ASC   = 3'd2,
    ST_RANGE     = 3'd3,
    ST_BAD_FIELD = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BASE_TIME   = 2'd0,
    REG_TRANS_COUNT = 2'd1,
    REG_TYPE_COUNT  = 2'd2,
    REG_NAME_SIZE   = 2'd3
  } cfg_reg_t;

  localparam int CFG_DATA_W = 63;
  localparam int COUNT_W    = 9;

  // Controller -> datapath
  typedef struct packed {
    logic capture;   // input transfer this cycle
    logic commit;    // finish a load: check, write, set result
    logic out_load;  // move result into output register
  } tzc_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic hit;        // scan found its entry this cycle
    logic scan_busy;  // scan pipeline still holds work
  } tzc_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/timezone_transition_convert.sv -----
// timezone_transition_convert: top level of the time zone transition converter.
// Depends on tzc_pkg, tzc_ctrl (sequencer) and tzc_dpath (tables and arithmetic).
`default_nettype none

// Converts times between UTC and local time using a loaded table of zone
// transitions and zone types. Load items (opcode 2, 3) write and validate
// table entries; convert items (opcode 0, 1) scan the transition table from
// the last entry in use toward entry 1, one entry per cycle through the
// transition memory read port, and fall back to entry 0. One item is worked
// on at a time. A convert item's result follows the matching entry; the scan
// rate is set by the one read port of the transition memory plus a
// three-stage lookup pipeline (transition read, type read, add and compare).
// A load item steps through capture, multiply, check and write, output. The
// result sits in an output register, so the next item is taken as soon as the
// current one has moved there, even while the consumer stalls. Table contents
// are not cleared by reset; converting through entries never loaded gives
// undefined fields.
// Configuration registers may only be written while no item is in flight.
module timezone_transition_convert #(
  parameter int MAX_TRANSITIONS  = 256,
  parameter int MAX_TYPES        = 256,
  parameter int TICKS_PER_SECOND = 10000000
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write port
  input  wire logic                           cfg_wr_en,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [tzc_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     opcode,
  input  wire logic [7:0]                     entry_index,
  input  wire logic signed [63:0]             time_in,
  input  wire logic signed [31:0]             seconds_value,
  input  wire logic [7:0]                     type_select,
  input  wire logic [7:0]                     dst_flag,
  input  wire logic [7:0]                     name_pos,
  // output channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [63:0]                  time_out,
  output logic [7:0]                          zone_type,
  output logic [7:0]                          zone_name_pos,
  output logic [2:0]                          status
);

  tzc_pkg::tzc_cmd_t  cmd;
  tzc_pkg::tzc_stat_t stat;

  // Sequencer: idle -> (load: multiply, write) or (convert: scan) -> output.
  tzc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .is_load   (opcode[1]),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // Tables, config registers, seconds scaler, scan pipeline, output register.
  tzc_dpath #(
    .MAX_TRANSITIONS  (MAX_TRANSITIONS),
    .MAX_TYPES        (MAX_TYPES),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (opcode),
    .entry_index   (entry_index),
    .time_in       (time_in),
    .seconds_value (seconds_value),
    .type_select   (type_select),
    .dst_flag      (dst_flag),
    .name_pos      (name_pos),
    .time_out      (time_out),
    .zone_type     (zone_type),
    .zone_name_pos (zone_name_pos),
    .status        (status)
  );

  // Only load results carry an error status, and loads return zero fields.
  a_err_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != tzc_pkg::ST_OK)) |->
      ((time_out == 64'sd0) && (zone_type == 8'd0) && (zone_name_pos == 8'd0)))
    else $error("error result with nonzero fields");

  // A scan match can only happen while an item is in flight.
  a_hit_busy: assert property (@(posedge clk) disable iff (rst)
    stat.hit |-> in_stall)
    else $error("scan hit while idle");

  // A new item never starts while the scan pipeline still holds work.
  a_capture_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !stat.scan_busy)
    else $error("transfer accepted with scan pipeline busy");

  // A result appears only after the block was busy with an item.
  a_out_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without preceding work");

endmodule

`default_nettype wire

// ----- hw/rtl/tzc_ctrl.sv -----
// tzc_ctrl: sequencing state machine for the time zone converter.
// Depends on tzc_pkg for the command and status structs.
`default_nettype none

module tzc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             is_load,
  input  wire logic             out_stall,
  input  wire tzc_pkg::tzc_stat_t stat,
  output tzc_pkg::tzc_cmd_t     cmd,
  output logic                  in_stall,
  output logic                  out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_MUL,
    S_LD_WR,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  always_comb begin
    in_stall     = (state != S_IDLE);
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.commit   = (state == S_LD_WR);
    cmd.out_load = (state == S_FINISH) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= is_load ? S_LD_MUL : S_SCAN;
        end
        S_LD_MUL: begin
          state <= S_LD_WR;
        end
        S_LD_WR: begin
          state <= S_FINISH;
        end
        S_SCAN: begin
          if (stat.hit) state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tzc_dpath.sv -----
// tzc_dpath: tables, config registers, scaler and scan pipeline.
// Depends on tzc_pkg; driven by tzc_ctrl through tzc_cmd_t.
`default_nettype none

module tzc_dpath #(
  parameter int MAX_TRANSITIONS  = 256,
  parameter int MAX_TYPES        = 256,
  parameter int TICKS_PER_SECOND = 10000000
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire tzc_pkg::tzc_cmd_t                 cmd,
  output tzc_pkg::tzc_stat_t                     stat,
  input  wire logic                              cfg_wr_en,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [tzc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [1:0]                        opcode,
  input  wire logic [7:0]                        entry_index,
  input  wire logic signed [63:0]                time_in,
  input  wire logic signed [31:0]                seconds_value,
  input  wire logic [7:0]                        type_select,
  input  wire logic [7:0]                        dst_flag,
  input  wire logic [7:0]                        name_pos,
  output logic signed [63:0]                     time_out,
  output logic [7:0]                             zone_type,
  output logic [7:0]                             zone_name_pos,
  output logic [2:0]                             status
);

  localparam int TAW = $clog2(MAX_TRANSITIONS);
  localparam int YAW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam logic [30:0] TPS_W = 31'(TICKS_PER_SECOND);

  // configuration
  logic [tzc_pkg::CFG_DATA_W-1:0] base_time;
  logic [tzc_pkg::COUNT_W-1:0]    trans_count;
  logic [tzc_pkg::COUNT_W-1:0]    type_count;
  logic [tzc_pkg::COUNT_W-1:0]    name_size;

  // captured item
  tzc_pkg::opcode_t   op_q;
  logic [7:0]         idx_q;
  logic signed [63:0] t_q;
  logic signed [31:0] secs_q;
  logic [7:0]         tsel_q;
  logic [7:0]         dst_q;
  logic [7:0]         npos_q;

  logic signed [31:0] prev_secs;
  logic signed [62:0] prod_full;
  logic [63:0]        prod;

  // tables: {time, type} and {offset, name}
  logic [71:0] tmem [MAX_TRANSITIONS];
  logic [71:0] ymem [MAX_TYPES];
  logic [71:0] tmem_q;
  logic [71:0] ymem_q;

  // scan pipeline
  logic               issue_active;
  logic [TAW-1:0]     scan_addr;
  logic [TAW-1:0]     scan_first;
  logic [31:0]        n_eff;
  logic               s1_valid, s1_zero;
  logic [7:0]         s1_type;
  logic               s2_valid, s2_zero;
  logic [63:0]        s2_time;
  logic [7:0]         s2_type;
  logic               s3_valid, s3_zero;
  logic signed [63:0] s3_time;
  logic signed [63:0] s3_arith;
  logic [7:0]         s3_type;
  logic [7:0]         s3_name;
  logic signed [63:0] cmp_lhs;
  logic               hit;

  // load checks
  tzc_pkg::status_t trans_status;
  tzc_pkg::status_t type_status;
  tzc_pkg::status_t load_status;
  logic             trans_we;
  logic             type_we;
  logic [63:0]      trans_time;

  // result holding register
  logic signed [63:0] res_time;
  logic [7:0]         res_type;
  logic [7:0]         res_name;
  tzc_pkg::status_t   res_status;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_time   <= '0;
      trans_count <= tzc_pkg::COUNT_W'(1);
      type_count  <= tzc_pkg::COUNT_W'(1);
      name_size   <= tzc_pkg::COUNT_W'(1);
    end else if (cfg_wr_en) begin
      unique case (tzc_pkg::cfg_reg_t'(cfg_index))
        tzc_pkg::REG_BASE_TIME:   base_time   <= cfg_data;
        tzc_pkg::REG_TRANS_COUNT: trans_count <= cfg_data[tzc_pkg::COUNT_W-1:0];
        tzc_pkg::REG_TYPE_COUNT:  type_count  <= cfg_data[tzc_pkg::COUNT_W-1:0];
        tzc_pkg::REG_NAME_SIZE:   name_size   <= cfg_data[tzc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= tzc_pkg::opcode_t'(opcode);
      idx_q  <= entry_index;
      t_q    <= time_in;
      secs_q <= seconds_value;
      tsel_q <= type_select;
      dst_q  <= dst_flag;
      npos_q <= name_pos;
    end
  end

  // seconds * ticks, exact in 63 bits
  assign prod_full = $signed({{31{secs_q[31]}}, secs_q}) * $signed({32'd0, TPS_W});

  always_ff @(posedge clk) begin
    prod <= {prod_full[62], prod_full};
  end

  // load validation
  always_comb begin
    if (({1'b0, idx_q} >= trans_count) || (32'(idx_q) >= 32'(MAX_TRANSITIONS)) ||
        ({1'b0, tsel_q} >= type_count) || (32'(tsel_q) >= 32'(MAX_TYPES))) begin
      trans_status = tzc_pkg::ST_RANGE;
    end else if ((idx_q != 8'd0) && (secs_q <= prev_secs)) begin
      trans_status = tzc_pkg::ST_NOT_ASC;
    end else begin
      trans_status = tzc_pkg::ST_OK;
    end

    if (({1'b0, idx_q} >= type_count) || (32'(idx_q) >= 32'(MAX_TYPES))) begin
      type_status = tzc_pkg::ST_RANGE;
    end else if ((dst_q > 8'd1) || ({1'b0, npos_q} >= name_size)) begin
      type_status = tzc_pkg::ST_BAD_FIELD;
    end else begin
      type_status = tzc_pkg::ST_OK;
    end

    load_status = (op_q == tzc_pkg::OP_LOAD_TRANS) ? trans_status : type_status;
  end

  assign trans_we   = cmd.commit && (op_q == tzc_pkg::OP_LOAD_TRANS) &&
                      (trans_status == tzc_pkg::ST_OK);
  assign type_we    = cmd.commit && (op_q == tzc_pkg::OP_LOAD_TYPE) &&
                      (type_status == tzc_pkg::ST_OK);
  assign trans_time = {1'b0, base_time} + prod;

  always_ff @(posedge clk) begin
    if (rst) prev_secs <= '0;
    else if (trans_we) prev_secs <= secs_q;
  end

  // scan start: clamped count minus one
  always_comb begin
    n_eff = 32'(trans_count);
    if (n_eff == 32'd0) n_eff = 32'd1;
    else if (n_eff > 32'(MAX_TRANSITIONS)) n_eff = 32'(MAX_TRANSITIONS);
    scan_first = TAW'(n_eff - 32'd1);
  end

  // issue: one transition entry per cycle, top down, entry 0 last
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_active <= 1'b0;
    end else if (cmd.capture && !opcode[1]) begin
      issue_active <= 1'b1;
    end else if (hit || (issue_active && (scan_addr == '0))) begin
      issue_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) scan_addr <= scan_first;
    else if (issue_active && (scan_addr != '0)) scan_addr <= scan_addr - 1'b1;
  end

  // transition table
  always_ff @(posedge clk) begin
    if (trans_we) tmem[TAW'(idx_q)] <= {trans_time, tsel_q};
    tmem_q <= tmem[scan_addr];
  end

  // stored type index outside the table falls back to type 0
  assign s1_type = (32'(tmem_q[7:0]) < 32'(MAX_TYPES)) ? tmem_q[7:0] : 8'd0;

  // type table
  always_ff @(posedge clk) begin
    if (type_we) ymem[YAW'(idx_q)] <= {prod, npos_q};
    ymem_q <= ymem[YAW'(s1_type)];
  end

  // stage valids, flushed on a hit
  always_ff @(posedge clk) begin
    if (rst || hit) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue_active;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_zero  <= (scan_addr == '0);
    s2_zero  <= s1_zero;
    s2_time  <= tmem_q[71:8];
    s2_type  <= s1_type;
    s3_zero  <= s2_zero;
    s3_time  <= s2_time;
    s3_type  <= s2_type;
    s3_name  <= ymem_q[7:0];
    s3_arith <= (op_q == tzc_pkg::OP_TO_LOCAL) ? (t_q + ymem_q[71:8])
                                              : (t_q - ymem_q[71:8]);
  end

  // UTC to local compares the input; local to UTC compares input minus offset
  assign cmp_lhs = (op_q == tzc_pkg::OP_TO_LOCAL) ? t_q : s3_arith;
  assign hit     = s3_valid && (s3_zero || (cmp_lhs >= s3_time));

  assign stat.hit       = hit;
  assign stat.scan_busy = issue_active | s1_valid | s2_valid | s3_valid;

  // result and output registers
  always_ff @(posedge clk) begin
    if (hit) begin
      res_time   <= s3_arith;
      res_type   <= s3_type;
      res_name   <= s3_name;
      res_status <= tzc_pkg::ST_OK;
    end else if (cmd.commit) begin
      res_time   <= '0;
      res_type   <= '0;
      res_name   <= '0;
      res_status <= load_status;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      time_out      <= res_time;
      zone_type     <= res_type;
      zone_name_pos <= res_name;
      status        <= res_status;
    end
  end

endmodule

`default_nettype wire
